// ===== rtl/core/lpcb_pkg.sv =====
package lpcb_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int SRC_W       = 3;
	localparam int COLOR_W     = 15;
	localparam int PRIO_W      = 2;
	localparam int MASK_W      = 6;
	localparam int WEIGHT_W    = 5;
	localparam int CHAN_W      = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 15;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 16;

	localparam logic [SRC_W-1:0]    BACKDROP_SRC = 3'd5;
	localparam logic [COLOR_W-1:0]  WHITE_COLOR  = 15'h7FFF;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 5'd16;
	localparam logic [CHAN_W-1:0]   CHAN_MAX     = 5'd31;

	typedef enum logic [1:0] {
		FX_NONE,
		FX_ALPHA,
		FX_BRIGHT_UP,
		FX_BRIGHT_DOWN
	} fx_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BACKDROP,
		REG_FORCE_BLANK,
		REG_EFFECT_MODE,
		REG_FIRST_MASK,
		REG_SECOND_MASK,
		REG_ALPHA_A,
		REG_ALPHA_B,
		REG_BRIGHT
	} reg_index_t;

	typedef struct packed {
		logic               valid;
		logic [SRC_W-1:0]   src;
		logic [COLOR_W-1:0] color;
		logic [PRIO_W-1:0]  prio;
		logic               transp;
		logic               semi;
	} cand_t;

	typedef struct packed {
		logic               top_ok;
		logic [SRC_W-1:0]   top_src;
		logic [COLOR_W-1:0] top_color;
		logic               top_semi;
		logic               sec_ok;
		logic [SRC_W-1:0]   sec_src;
		logic [COLOR_W-1:0] sec_color;
		logic               win_fx;
	} dot_rec_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  backdrop_color;
		logic                force_blank;
		fx_mode_t            effect_mode;
		logic [MASK_W-1:0]   first_mask;
		logic [MASK_W-1:0]   second_mask;
		logic [WEIGHT_W-1:0] alpha_a;
		logic [WEIGHT_W-1:0] alpha_b;
		logic [WEIGHT_W-1:0] bright;
	} cfg_t;

endpackage

// ===== rtl/core/layer_priority_color_blender_core.sv =====
// Layer compositor for one screen dot at a time. Candidate layer pixels stream in one word per
// cycle while the queue has room, the dot closing on the word with tlast; the front keeps the two
// best candidates and on tlast hands the dot to a short queue, from which the back applies the
// backdrop, alpha blend or brightness effect and presents one BGR555 word. Throughput is one input
// word per clock while the queue is not full. The queue takes a dot on the edge that takes its
// tlast word, and the output register takes its colour from the queue once the output is free.
// The queue depth (QUEUE_DEPTH dots) sets how long the output may stall before s_axis_tready
// drops. Configuration writes are taken every cycle and belong between dots.
module layer_priority_color_blender_core #(
	parameter int QUEUE_DEPTH = lpcb_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// layer_source[2:0], pixel_color[17:3], priority_req[19:18], is_transparent[20],
	// is_semi_transparent[21], effects_enabled[22], zero[23]
	input  logic [lpcb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// present[0]
	input  logic [0:0]                          s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_color[14:0], zero[15]
	output logic [lpcb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lpcb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	lpcb_pkg::cfg_t               cfg_q;
	lpcb_pkg::cand_t              cand;
	lpcb_pkg::dot_rec_t           push_rec, head_rec;
	logic                         push, pop, q_full, q_not_empty;
	logic [lpcb_pkg::COLOR_W-1:0] out_color;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpcb_pkg::REG_BACKDROP:    cfg_q.backdrop_color <= cfg_data;
				lpcb_pkg::REG_FORCE_BLANK: cfg_q.force_blank    <= cfg_data[0];
				lpcb_pkg::REG_EFFECT_MODE: cfg_q.effect_mode    <= lpcb_pkg::fx_mode_t'(cfg_data[1:0]);
				lpcb_pkg::REG_FIRST_MASK:  cfg_q.first_mask     <= cfg_data[5:0];
				lpcb_pkg::REG_SECOND_MASK: cfg_q.second_mask    <= cfg_data[5:0];
				lpcb_pkg::REG_ALPHA_A:     cfg_q.alpha_a        <= cfg_data[4:0];
				lpcb_pkg::REG_ALPHA_B:     cfg_q.alpha_b        <= cfg_data[4:0];
				lpcb_pkg::REG_BRIGHT:      cfg_q.bright         <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cand.valid  = 1'b1;
		cand.src    = s_axis_tdata[2:0];
		cand.color  = s_axis_tdata[17:3];
		cand.prio   = s_axis_tdata[19:18];
		cand.transp = s_axis_tdata[20];
		cand.semi   = s_axis_tdata[21];
	end

	lpcb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.present         (s_axis_tuser[0]),
		.cand            (cand),
		.last_of_dot     (s_axis_tlast),
		.effects_enabled (s_axis_tdata[22]),
		.q_full          (q_full),
		.push            (push),
		.push_rec        (push_rec)
	);

	lpcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_rec),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rdata     (head_rec)
	);

	lpcb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_valid (q_not_empty),
		.rec       (head_rec),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_color (out_color)
	);

	assign m_axis_tdata = {1'b0, out_color};

endmodule

// ===== rtl/core/lpcb_front.sv =====
module lpcb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             present,
	input  lpcb_pkg::cand_t  cand,
	input  logic             last_of_dot,
	input  logic             effects_enabled,
	input  logic             q_full,
	output logic             push,
	output lpcb_pkg::dot_rec_t push_rec
);

	lpcb_pkg::cand_t best_q, second_q;
	lpcb_pkg::cand_t best_nxt, second_nxt;
	logic            accept;

	function automatic logic ranks_before(input lpcb_pkg::cand_t a, input lpcb_pkg::cand_t b);
		return {a.transp, a.prio, a.src} < {b.transp, b.prio, b.src};
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last_of_dot;

	always_comb begin
		best_nxt   = best_q;
		second_nxt = second_q;
		if (present) begin
			if (!best_q.valid || ranks_before(cand, best_q)) begin
				best_nxt   = cand;
				second_nxt = best_q;
			end else if (!second_q.valid || ranks_before(cand, second_q)) begin
				second_nxt = cand;
			end
		end
	end

	always_comb begin
		push_rec.top_ok    = best_nxt.valid && !best_nxt.transp;
		push_rec.top_src   = best_nxt.src;
		push_rec.top_color = best_nxt.color;
		push_rec.top_semi  = best_nxt.semi;
		push_rec.sec_ok    = push_rec.top_ok && second_nxt.valid && !second_nxt.transp;
		push_rec.sec_src   = second_nxt.src;
		push_rec.sec_color = second_nxt.color;
		push_rec.win_fx    = effects_enabled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (last_of_dot) begin
				best_q   <= '0;
				second_q <= '0;
			end else begin
				best_q   <= best_nxt;
				second_q <= second_nxt;
			end
		end
	end

endmodule

// ===== rtl/core/lpcb_queue.sv =====
module lpcb_queue #(
	parameter int DEPTH = lpcb_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lpcb_pkg::dot_rec_t wdata,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output lpcb_pkg::dot_rec_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lpcb_pkg::dot_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/lpcb_back.sv =====
module lpcb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpcb_pkg::cfg_t                cfg,
	input  logic                          rec_valid,
	input  lpcb_pkg::dot_rec_t            rec,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpcb_pkg::COLOR_W-1:0]  out_color
);

	localparam int CW = lpcb_pkg::CHAN_W;
	localparam int WW = lpcb_pkg::WEIGHT_W;

	logic                         out_valid_q;
	logic [lpcb_pkg::COLOR_W-1:0] out_color_q;

	logic [lpcb_pkg::SRC_W-1:0]   a_src;
	logic [lpcb_pkg::COLOR_W-1:0] a_color;
	logic                         a_semi;
	lpcb_pkg::fx_mode_t           mode;
	logic [WW-1:0]                ea, eb, ey;
	logic [lpcb_pkg::COLOR_W-1:0] blend_color, up_color, down_color, color;

	function automatic logic [WW-1:0] clamp16(input logic [WW-1:0] v);
		return (v > lpcb_pkg::WEIGHT_MAX) ? lpcb_pkg::WEIGHT_MAX : v;
	endfunction

	function automatic logic mask_bit(input logic [lpcb_pkg::MASK_W-1:0] mask,
			input logic [lpcb_pkg::SRC_W-1:0] src);
		logic [7:0] m;
		m = {2'b00, mask};
		return m[src];
	endfunction

	function automatic logic [CW-1:0] blend_chan(input logic [WW-1:0] wa,
			input logic [WW-1:0] wb, input logic [CW-1:0] ca, input logic [CW-1:0] cb);
		logic [9:0] s;
		s = ({5'b0, wa} * {5'b0, ca}) + ({5'b0, wb} * {5'b0, cb});
		return (s[9:4] > {1'b0, lpcb_pkg::CHAN_MAX}) ? lpcb_pkg::CHAN_MAX : s[8:4];
	endfunction

	function automatic logic [CW-1:0] up_chan(input logic [WW-1:0] w, input logic [CW-1:0] c);
		logic [9:0] s;
		s = {1'b0, c, 4'b0} + ({5'b0, lpcb_pkg::CHAN_MAX - c} * {5'b0, w});
		return s[8:4];
	endfunction

	function automatic logic [CW-1:0] down_chan(input logic [WW-1:0] w, input logic [CW-1:0] c);
		logic [9:0] s;
		s = {1'b0, c, 4'b0} - ({5'b0, c} * {5'b0, w});
		return s[8:4];
	endfunction

	assign pop       = rec_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_color = out_color_q;

	assign ea = clamp16(cfg.alpha_a);
	assign eb = clamp16(cfg.alpha_b);
	assign ey = clamp16(cfg.bright);

	always_comb begin
		a_src   = rec.top_ok ? rec.top_src : lpcb_pkg::BACKDROP_SRC;
		a_color = rec.top_ok ? rec.top_color : cfg.backdrop_color;
		a_semi  = rec.top_ok && rec.top_semi;
		if (a_semi && rec.sec_ok) begin
			mode = lpcb_pkg::FX_ALPHA;
		end else if (!rec.win_fx) begin
			mode = lpcb_pkg::FX_NONE;
		end else begin
			mode = cfg.effect_mode;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			blend_color[k*CW +: CW] = blend_chan(ea, eb, a_color[k*CW +: CW],
				rec.sec_color[k*CW +: CW]);
			up_color[k*CW +: CW]    = up_chan(ey, a_color[k*CW +: CW]);
			down_color[k*CW +: CW]  = down_chan(ey, a_color[k*CW +: CW]);
		end
	end

	always_comb begin
		color = a_color;
		case (mode)
			lpcb_pkg::FX_ALPHA: begin
				if (rec.sec_ok && (mask_bit(cfg.first_mask, a_src) || a_semi) &&
						mask_bit(cfg.second_mask, rec.sec_src)) begin
					color = blend_color;
				end
			end
			lpcb_pkg::FX_BRIGHT_UP: begin
				if (mask_bit(cfg.first_mask, a_src)) begin
					color = up_color;
				end
			end
			lpcb_pkg::FX_BRIGHT_DOWN: begin
				if (mask_bit(cfg.first_mask, a_src)) begin
					color = down_color;
				end
			end
			default: begin
				color = a_color;
			end
		endcase
		if (cfg.force_blank) begin
			color = lpcb_pkg::WHITE_COLOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_color_q <= color;
		end
	end

endmodule

// ===== rtl/core/lpcb_checker.sv =====
module lpcb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                s_axis_tlast,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [lpcb_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_dot_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && s_axis_tvalid && s_axis_tready && s_axis_tlast |-> ##2 m_axis_tvalid)
		else $error("closed dot did not reach empty output");

endmodule

bind layer_priority_color_blender_core lpcb_checker u_lpcb_checker (.*);

// ===== sim/layer_priority_color_blender_core_tb.sv =====
module layer_priority_color_blender_core_tb;

	typedef logic [lpcb_pkg::COLOR_W-1:0]    color_t;
	typedef logic [lpcb_pkg::SRC_W-1:0]      src_t;
	typedef logic [lpcb_pkg::PRIO_W-1:0]     prio_t;
	typedef logic [lpcb_pkg::MASK_W-1:0]     mask_t;
	typedef logic [lpcb_pkg::WEIGHT_W-1:0]   weight_t;
	typedef logic [lpcb_pkg::CFG_DATA_W-1:0] cfg_data_t;

	typedef struct packed {
		logic                 is_cfg;
		lpcb_pkg::reg_index_t idx;
		color_t               value;
		logic                 present;
		src_t                 src;
		color_t               color;
		prio_t                prio;
		logic                 transp;
		logic                 semi;
		logic                 fx;
		logic                 last;
		logic                 pinned;
		color_t               pinned_color;
	} plan_row_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_axis_tvalid;
	logic                                 s_axis_tready;
	logic [lpcb_pkg::IN_DATA_W-1:0]       s_axis_tdata;
	logic [0:0]                           s_axis_tuser;
	logic                                 s_axis_tlast;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready;
	logic [lpcb_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [lpcb_pkg::CFG_INDEX_W-1:0]     cfg_index;
	logic [lpcb_pkg::CFG_DATA_W-1:0]      cfg_data;

	logic   note_pinned;
	color_t note_color;

	lpcb_pkg::cand_t top_pix = '0;
	lpcb_pkg::cand_t next_pix = '0;
	lpcb_pkg::cfg_t  regs = '0;
	color_t          colors_due[$];
	plan_row_t       plan[$];
	int              mismatches = 0;
	int              words_sent = 0;
	int              burst_left = 0;
	bit              hold_req = 1'b0;

	layer_priority_color_blender_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("layer_priority_color_blender_core verification failed");
		$finish;
	end

	function automatic bit outranks(lpcb_pkg::cand_t a, lpcb_pkg::cand_t b);
		if (a.transp != b.transp)
			return !a.transp;
		if (a.prio != b.prio)
			return a.prio < b.prio;
		return a.src < b.src;
	endfunction

	function automatic int unsigned weight16(weight_t w);
		return (w > lpcb_pkg::WEIGHT_MAX) ? 16 : int'(w);
	endfunction

	function automatic bit is_target(mask_t mask, src_t src);
		logic [7:0] wide;
		wide = {2'b00, mask};
		return wide[src];
	endfunction

	function automatic color_t mix_alpha(int unsigned ea, int unsigned eb,
			color_t ca, color_t cb);
		color_t res;
		int unsigned x, y, v;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			x = ca[5*k +: 5] * 16;
			y = cb[5*k +: 5] * 16;
			v = (ea * x + eb * y) >> 8;
			if (v > 31)
				v = 31;
			res[5*k +: 5] = v[4:0];
		end
		return res;
	endfunction

	function automatic color_t shade(bit up, int unsigned ey, color_t c);
		color_t res;
		int unsigned x, v;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			x = c[5*k +: 5] * 16;
			if (up)
				v = (x + (((496 - x) * ey) >> 4)) >> 4;
			else
				v = (x - ((x * ey) >> 4)) >> 4;
			res[5*k +: 5] = v[4:0];
		end
		return res;
	endfunction

	function automatic color_t dot_color(bit win_fx);
		lpcb_pkg::cand_t    top;
		lpcb_pkg::cand_t    sec;
		bit                 has_sec;
		lpcb_pkg::fx_mode_t mode;
		color_t             res;
		if (regs.force_blank)
			return lpcb_pkg::WHITE_COLOR;
		has_sec = 1'b0;
		sec = next_pix;
		if (!top_pix.valid || top_pix.transp) begin
			top = '0;
			top.valid = 1'b1;
			top.src = lpcb_pkg::BACKDROP_SRC;
			top.color = regs.backdrop_color;
		end else begin
			top = top_pix;
			has_sec = next_pix.valid && !next_pix.transp;
		end
		mode = regs.effect_mode;
		if (top.semi && has_sec)
			mode = lpcb_pkg::FX_ALPHA;
		else if (!win_fx)
			mode = lpcb_pkg::FX_NONE;
		res = top.color;
		case (mode)
		lpcb_pkg::FX_ALPHA: begin
			if (has_sec && (is_target(regs.first_mask, top.src) || top.semi) &&
					is_target(regs.second_mask, sec.src))
				res = mix_alpha(weight16(regs.alpha_a), weight16(regs.alpha_b),
						top.color, sec.color);
		end
		lpcb_pkg::FX_BRIGHT_UP: begin
			if (is_target(regs.first_mask, top.src))
				res = shade(1'b1, weight16(regs.bright), top.color);
		end
		lpcb_pkg::FX_BRIGHT_DOWN: begin
			if (is_target(regs.first_mask, top.src))
				res = shade(1'b0, weight16(regs.bright), top.color);
		end
		default: ;
		endcase
		return res;
	endfunction

	function automatic void queue_color(color_t c);
		colors_due = {colors_due, c};
	endfunction

	always @(posedge clk) begin : watch
		lpcb_pkg::cand_t c;
		color_t          want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (colors_due.size() == 0) begin
					$error("out_color: no result expected, got %h",
							m_axis_tdata[lpcb_pkg::COLOR_W-1:0]);
					mismatches++;
				end else begin
					want = colors_due.pop_front();
					if (m_axis_tdata[lpcb_pkg::COLOR_W-1:0] !== want) begin
						$error("out_color: expected %h, got %h", want,
								m_axis_tdata[lpcb_pkg::COLOR_W-1:0]);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				lpcb_pkg::REG_BACKDROP:    regs.backdrop_color = cfg_data;
				lpcb_pkg::REG_FORCE_BLANK: regs.force_blank = cfg_data[0];
				lpcb_pkg::REG_EFFECT_MODE: regs.effect_mode = lpcb_pkg::fx_mode_t'(cfg_data[1:0]);
				lpcb_pkg::REG_FIRST_MASK:  regs.first_mask = cfg_data[lpcb_pkg::MASK_W-1:0];
				lpcb_pkg::REG_SECOND_MASK: regs.second_mask = cfg_data[lpcb_pkg::MASK_W-1:0];
				lpcb_pkg::REG_ALPHA_A:     regs.alpha_a = cfg_data[lpcb_pkg::WEIGHT_W-1:0];
				lpcb_pkg::REG_ALPHA_B:     regs.alpha_b = cfg_data[lpcb_pkg::WEIGHT_W-1:0];
				lpcb_pkg::REG_BRIGHT:      regs.bright = cfg_data[lpcb_pkg::WEIGHT_W-1:0];
				default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0]) begin
					c.valid = 1'b1;
					c.src = s_axis_tdata[2:0];
					c.color = s_axis_tdata[17:3];
					c.prio = s_axis_tdata[19:18];
					c.transp = s_axis_tdata[20];
					c.semi = s_axis_tdata[21];
					if (!top_pix.valid || outranks(c, top_pix)) begin
						next_pix = top_pix;
						top_pix = c;
					end else if (!next_pix.valid || outranks(c, next_pix)) begin
						next_pix = c;
					end
				end
				if (s_axis_tlast) begin
					queue_color(note_pinned ? note_color : dot_color(s_axis_tdata[22]));
					top_pix = '0;
					next_pix = '0;
				end
			end
		end
	end

	// receiver: stall on changing patterns, hold off for a long stretch on request
	initial begin : drain_side
		int pat_left;
		int pat_mode;
		pat_left = 0;
		pat_mode = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (100) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(8, 80);
				end
				pat_left--;
				case (pat_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	function automatic plan_row_t crow(lpcb_pkg::reg_index_t idx, color_t value);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.value = value;
		return r;
	endfunction

	function automatic plan_row_t wrow(logic present, src_t src,
			color_t color, prio_t prio, logic transp, logic semi,
			logic fx, logic last, logic pinned, color_t pinned_color);
		plan_row_t r;
		r = '0;
		r.present = present;
		r.src = src;
		r.color = color;
		r.prio = prio;
		r.transp = transp;
		r.semi = semi;
		r.fx = fx;
		r.last = last;
		r.pinned = pinned;
		r.pinned_color = pinned_color;
		return r;
	endfunction

	function automatic void add_row(plan_row_t r);
		plan = {plan, r};
	endfunction

	function automatic color_t pick_color();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return lpcb_pkg::WHITE_COLOR;
		default: return color_t'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic mask_t pick_mask();
		case ($urandom_range(0, 4))
		0: return '0;
		1: return 6'h3F;
		default: return mask_t'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic weight_t pick_weight();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return lpcb_pkg::WEIGHT_MAX;
		2: return 5'd31;
		default: return weight_t'($urandom_range(0, 31));
		endcase
	endfunction

	task automatic send_word(input logic present, input src_t src,
			input color_t color, input prio_t prio,
			input logic transp, input logic semi, input logic fx, input logic last,
			input logic pinned, input color_t pinned_color);
		int gap;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, fx, semi, transp, prio, color, src};
		s_axis_tuser <= present;
		s_axis_tlast <= last;
		note_pinned <= pinned;
		note_color <= pinned_color;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input lpcb_pkg::reg_index_t idx, input cfg_data_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// drop valid and hold until every dot has come out
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (colors_due.size() != 0) @(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic pause_until_done();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (colors_due.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_rand(input logic last);
		logic   present;
		src_t   src;
		color_t color;
		prio_t  prio;
		present = last ? ($urandom_range(0, 9) >= 3) : ($urandom_range(0, 19) != 0);
		if ($urandom_range(0, 9) == 0)
			src = src_t'($urandom_range(5, 7));
		else
			src = src_t'($urandom_range(0, 4));
		color = pick_color();
		prio = prio_t'($urandom_range(0, 3));
		send_word(present, src, color, prio, $urandom_range(0, 3) == 0,
				$urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0, last, 1'b0, '0);
		words_sent++;
	endtask

	task automatic send_dot(input bit single);
		int n;
		n = single ? 0 : $urandom_range(0, 5);
		repeat (n) send_rand(1'b0);
		send_rand(1'b1);
	endtask

	initial begin : feed_side
		int phase;
		int waited;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		s_axis_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		note_pinned <= 1'b0;
		note_color <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(crow(lpcb_pkg::REG_BACKDROP, 15'h1234));
		add_row(wrow(0, 0, 15'h0000, 0, 0, 0, 0, 1, 1, 15'h1234));
		add_row(wrow(1, 0, 15'h7FFF, 0, 0, 0, 1, 1, 1, 15'h7FFF));
		add_row(wrow(1, 4, 15'h0000, 3, 1, 0, 1, 1, 1, 15'h1234));
		add_row(crow(lpcb_pkg::REG_FORCE_BLANK, 15'd1));
		add_row(wrow(1, 2, 15'h0000, 1, 0, 0, 1, 1, 1, lpcb_pkg::WHITE_COLOR));
		add_row(crow(lpcb_pkg::REG_FORCE_BLANK, 15'd0));
		add_row(crow(lpcb_pkg::REG_EFFECT_MODE, color_t'(lpcb_pkg::FX_ALPHA)));
		add_row(crow(lpcb_pkg::REG_FIRST_MASK, 15'h3F));
		add_row(crow(lpcb_pkg::REG_SECOND_MASK, 15'h3F));
		add_row(crow(lpcb_pkg::REG_ALPHA_A, 15'd31));
		add_row(crow(lpcb_pkg::REG_ALPHA_B, 15'd5));
		add_row(wrow(1, 1, 15'h7C1F, 1, 0, 0, 0, 0, 0, 0));
		add_row(wrow(1, 3, 15'h03E0, 1, 0, 0, 1, 1, 0, 0));
		add_row(wrow(1, 2, 15'h1111, 2, 0, 0, 0, 0, 0, 0));
		add_row(wrow(1, 2, 15'h2222, 2, 0, 0, 1, 1, 0, 0));
		add_row(wrow(1, 0, 15'h7FFF, 0, 0, 1, 0, 0, 0, 0));
		add_row(wrow(1, 1, 15'h7FFF, 1, 0, 0, 0, 1, 0, 0));
		add_row(wrow(1, 1, 15'h0ABC, 2, 0, 0, 1, 0, 0, 0));
		add_row(wrow(0, 7, 15'h7FFF, 3, 1, 1, 0, 1, 1, 15'h0ABC));
		add_row(wrow(1, 7, 15'h5555, 0, 0, 0, 1, 0, 0, 0));
		add_row(wrow(1, 5, 15'h2AAA, 0, 0, 0, 1, 1, 0, 0));
		add_row(wrow(1, 0, 15'h3333, 0, 0, 0, 1, 0, 0, 0));
		add_row(wrow(1, 1, 15'h4444, 0, 1, 0, 1, 1, 0, 0));
		add_row(wrow(1, 0, 15'h0000, 0, 1, 0, 1, 0, 0, 0));
		add_row(wrow(1, 4, 15'h1F00, 3, 0, 1, 1, 1, 0, 0));
		add_row(crow(lpcb_pkg::REG_EFFECT_MODE, color_t'(lpcb_pkg::FX_BRIGHT_UP)));
		add_row(crow(lpcb_pkg::REG_BRIGHT, 15'd16));
		add_row(wrow(1, 3, 15'h0000, 0, 0, 0, 1, 1, 1, lpcb_pkg::WHITE_COLOR));
		add_row(crow(lpcb_pkg::REG_EFFECT_MODE, color_t'(lpcb_pkg::FX_BRIGHT_DOWN)));
		add_row(crow(lpcb_pkg::REG_BRIGHT, 15'd31));
		add_row(wrow(1, 0, 15'h7FFF, 0, 0, 0, 1, 1, 1, 15'h0000));
		add_row(crow(lpcb_pkg::REG_BRIGHT, 15'd8));
		add_row(wrow(0, 0, 15'h0000, 0, 0, 0, 1, 1, 0, 0));
		add_row(crow(lpcb_pkg::REG_FIRST_MASK, 15'd0));
		add_row(wrow(1, 0, 15'h4321, 0, 0, 0, 1, 1, 1, 15'h4321));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_word(plan[i].present, plan[i].src, plan[i].color, plan[i].prio,
						plan[i].transp, plan[i].semi, plan[i].fx, plan[i].last,
						plan[i].pinned, plan[i].pinned_color);
			end
		end

		phase = 0;
		while (words_sent < 1650) begin
			settle();
			write_reg(lpcb_pkg::REG_BACKDROP, pick_color());
			write_reg(lpcb_pkg::REG_FORCE_BLANK, cfg_data_t'($urandom_range(0, 7) == 0));
			write_reg(lpcb_pkg::REG_EFFECT_MODE, cfg_data_t'(phase % 4));
			write_reg(lpcb_pkg::REG_FIRST_MASK, cfg_data_t'(pick_mask()));
			write_reg(lpcb_pkg::REG_SECOND_MASK, cfg_data_t'(pick_mask()));
			write_reg(lpcb_pkg::REG_ALPHA_A, cfg_data_t'(pick_weight()));
			write_reg(lpcb_pkg::REG_ALPHA_B, cfg_data_t'(pick_weight()));
			write_reg(lpcb_pkg::REG_BRIGHT, cfg_data_t'(pick_weight()));
			if (phase == 1)
				hold_req = 1'b1;
			for (int dots = 0; dots < 40; dots++) begin
				if (phase != 1 && (dots == 20 || $urandom_range(0, 49) == 0))
					pause_until_done();
				send_dot(phase == 1 && dots < 30);
			end
			phase++;
		end

		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		for (waited = 0; colors_due.size() != 0 && waited < 5000; waited++)
			@(negedge clk);
		if (colors_due.size() != 0) begin
			$error("out_color: %0d results never arrived", colors_due.size());
			mismatches++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("layer_priority_color_blender_core verification clean");
		else
			$display("layer_priority_color_blender_core verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lpcb_pkg.sv
rtl/core/lpcb_front.sv
rtl/core/lpcb_queue.sv
rtl/core/lpcb_back.sv
rtl/core/layer_priority_color_blender_core.sv
rtl/core/lpcb_checker.sv
sim/layer_priority_color_blender_core_tb.sv
